>>> src/gpio_pkg.sv
// Shared types, command codes, register offsets and sizes for the GPIO port pin resolver.
`timescale 1ns / 1ps
`default_nettype none

package gpio_pkg;

    // Number of resolved pins; the port registers are sized for sixteen
    localparam int NUM_PINS = 16;

    // Command codes carried in a request beat
    localparam logic [2:0] CMD_READ       = 3'd0;
    localparam logic [2:0] CMD_WRITE      = 3'd1;
    localparam logic [2:0] CMD_DRIVE      = 3'd2;
    localparam logic [2:0] CMD_DISCONNECT = 3'd3;
    localparam logic [2:0] CMD_PORT_RESET = 3'd4;

    // Register byte offsets on the bus
    localparam logic [9:0] OFS_MODE      = 10'h000;
    localparam logic [9:0] OFS_TYPE      = 10'h004;
    localparam logic [9:0] OFS_SPEED     = 10'h008;
    localparam logic [9:0] OFS_PULL      = 10'h00C;
    localparam logic [9:0] OFS_IN        = 10'h010;
    localparam logic [9:0] OFS_OUT       = 10'h014;
    localparam logic [9:0] OFS_SETRESET  = 10'h018;
    localparam logic [9:0] OFS_LOCK      = 10'h01C;
    localparam logic [9:0] OFS_ALTLO     = 10'h020;
    localparam logic [9:0] OFS_ALTHI     = 10'h024;
    localparam logic [9:0] OFS_RESETONLY = 10'h028;
    localparam logic [9:0] OFS_ANALOG    = 10'h02C;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE_RESET  = 2'd0;
    localparam logic [1:0] CFG_SPEED_RESET = 2'd1;
    localparam logic [1:0] CFG_PULL_RESET  = 2'd2;

    // Pin mode and pull codes
    localparam logic [1:0] MODE_OUTPUT = 2'd1;
    localparam logic [1:0] PULL_UP     = 2'd1;
    localparam logic [1:0] PULL_DOWN   = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [9:0]  addr;
        logic [31:0] write_data;
        logic [3:0]  pin_index;
        logic        pin_level_in;
        logic [15:0] disconnect_mask;
    } gpio_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] input_levels;
        logic [15:0] rise_mask;
        logic [15:0] fall_mask;
        logic        drive_refused;
        logic        bad_offset;
    } gpio_rsp_t;

endpackage

`default_nettype wire

>>> src/gpio_port_pin_resolver_unit.sv
// Top level of the GPIO port pin resolver: request register, pin resolution, result register.
//
// Usage: one request beat per command (bus read, bus write, external pin drive,
// pin disconnect, port reset) enters on req/req_valid and is accepted at a clock
// edge with req_valid high and req_stall low. Every request gives exactly one
// result beat on rsp/rsp_valid, taken at an edge with rsp_stall low.
// A request passes the request register, then one pass of per-pin
// resolution logic that updates the port state and loads the result register.
// Throughput is one beat per cycle while rsp_stall is low; a new request is taken while a result waits.
// When the receiver stalls, the result register holds its beat and the request
// register fills; req_stall rises only while both are full and rsp_stall is high.
// The reset-value registers are written on cfg (cfg_ready is always high); the user must write
// them only while the port is idle, which the block does not enforce. Reset (rst_n low) clears
// the port: all pins disconnected, all registers zero, reset values zero, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module gpio_port_pin_resolver_unit
    import gpio_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire gpio_req_t   req,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output gpio_rsp_t        rsp,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    // Resolve every pin's input level; floating pins keep prev
    function automatic logic [15:0] resolve_levels(
        input logic [31:0] modes,
        input logic [15:0] types,
        input logic [15:0] odata,
        input logic [31:0] pulls,
        input logic [15:0] disc,
        input logic [15:0] high,
        input logic [15:0] prev
    );
        logic [15:0] now;
        logic [1:0]  m;
        logic [1:0]  p;
        now = prev;
        for (int i = 0; i < NUM_PINS; i++) begin
            m = modes[2*i +: 2];
            p = pulls[2*i +: 2];
            if (m == MODE_OUTPUT) begin
                if (!types[i] || !odata[i]) begin
                    now[i] = odata[i];
                end
                else if (!disc[i] && !high[i]) begin
                    now[i] = 1'b0;
                end
                else if (p == PULL_UP) begin
                    now[i] = 1'b1;
                end
                else if (p == PULL_DOWN) begin
                    now[i] = 1'b0;
                end
            end
            else if (!disc[i]) begin
                now[i] = high[i];
            end
            else if (p == PULL_UP) begin
                now[i] = 1'b1;
            end
            else if (p == PULL_DOWN) begin
                now[i] = 1'b0;
            end
        end
        return now;
    endfunction

    // Connected output pins that fight the new configuration
    function automatic logic [15:0] conflict_pins(
        input logic [31:0] modes,
        input logic [15:0] types,
        input logic [15:0] disc,
        input logic [15:0] high
    );
        logic [15:0] hit;
        hit = '0;
        for (int i = 0; i < NUM_PINS; i++) begin
            hit[i] = !disc[i] && (modes[2*i +: 2] == MODE_OUTPUT) && (!types[i] || high[i]);
        end
        return hit;
    endfunction

    // Reset-value registers
    logic [31:0] mode_rst_reg;
    logic [31:0] speed_rst_reg;
    logic [31:0] pull_rst_reg;

    // Port state
    logic [31:0] modes_reg, modes_next;
    logic [15:0] types_reg, types_next;
    logic [31:0] speeds_reg, speeds_next;
    logic [31:0] pulls_reg, pulls_next;
    logic [15:0] in_data_reg, in_data_next;
    logic [15:0] out_data_reg, out_data_next;
    logic [15:0] lock_reg, lock_next;
    logic [31:0] alt_lo_reg, alt_lo_next;
    logic [31:0] alt_hi_reg, alt_hi_next;
    logic [15:0] analog_reg, analog_next;
    logic [15:0] disc_reg, disc_next;
    logic [15:0] high_reg, high_next;

    // Pipeline stages
    gpio_req_t   req_reg;
    logic        req_valid_reg;
    gpio_rsp_t   rsp_reg, rsp_next;
    logic        rsp_valid_reg;
    logic        advance;

    // Step working signals
    logic        do_resolve;
    logic [15:0] prev_levels;
    logic [15:0] now_levels;
    logic [15:0] hit;
    logic        pin_ok;
    logic [3:0]  pin;

    assign cfg_ready = 1'b1;
    assign advance   = req_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = req_valid_reg && !(!rsp_valid_reg || !rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pin       = req_reg.pin_index;
    assign pin_ok    = ({1'b0, pin} < 5'(NUM_PINS));

    // Hold the reset-value registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_rst_reg  <= '0;
            speed_rst_reg <= '0;
            pull_rst_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MODE_RESET:  mode_rst_reg  <= cfg_data;
                CFG_SPEED_RESET: speed_rst_reg <= cfg_data;
                CFG_PULL_RESET:  pull_rst_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Execute the held command against the port state
    always_comb
    begin
        modes_next    = modes_reg;
        types_next    = types_reg;
        speeds_next   = speeds_reg;
        pulls_next    = pulls_reg;
        in_data_next  = in_data_reg;
        out_data_next = out_data_reg;
        lock_next     = lock_reg;
        alt_lo_next   = alt_lo_reg;
        alt_hi_next   = alt_hi_reg;
        analog_next   = analog_reg;
        disc_next     = disc_reg;
        high_next     = high_reg;
        rsp_next      = '0;
        do_resolve    = 1'b0;
        prev_levels   = in_data_reg;
        hit           = '0;

        case (req_reg.cmd)
            CMD_READ:
            begin
                case (req_reg.addr)
                    OFS_MODE:      rsp_next.read_data = modes_reg;
                    OFS_TYPE:      rsp_next.read_data = {16'h0, types_reg};
                    OFS_SPEED:     rsp_next.read_data = speeds_reg;
                    OFS_PULL:      rsp_next.read_data = pulls_reg;
                    OFS_IN:        rsp_next.read_data = {16'h0, in_data_reg};
                    OFS_OUT:       rsp_next.read_data = {16'h0, out_data_reg};
                    OFS_SETRESET:  rsp_next.read_data = '0;
                    OFS_LOCK:      rsp_next.read_data = {16'h0, lock_reg};
                    OFS_ALTLO:     rsp_next.read_data = alt_lo_reg;
                    OFS_ALTHI:     rsp_next.read_data = alt_hi_reg;
                    OFS_RESETONLY: rsp_next.read_data = '0;
                    OFS_ANALOG:    rsp_next.read_data = {16'h0, analog_reg};
                    default:       rsp_next.bad_offset = 1'b1;
                endcase
            end
            CMD_WRITE:
            begin
                case (req_reg.addr)
                    OFS_MODE, OFS_TYPE:
                    begin
                        if (req_reg.addr == OFS_MODE)
                            modes_next = req_reg.write_data;
                        else
                            types_next = req_reg.write_data[15:0];
                        hit = conflict_pins(modes_next, types_next, disc_reg, high_reg);
                        disc_next = disc_reg | hit;
                        rsp_next.drive_refused = |hit;
                        do_resolve = 1'b1;
                    end
                    OFS_SPEED: speeds_next = req_reg.write_data;
                    OFS_PULL:
                    begin
                        pulls_next = req_reg.write_data;
                        do_resolve = 1'b1;
                    end
                    OFS_IN:    ;
                    OFS_OUT:
                    begin
                        out_data_next = req_reg.write_data[15:0];
                        do_resolve = 1'b1;
                    end
                    OFS_SETRESET:
                    begin
                        // Set bits win over reset bits
                        out_data_next = (out_data_reg & ~req_reg.write_data[31:16])
                                      | req_reg.write_data[15:0];
                        do_resolve = 1'b1;
                    end
                    OFS_LOCK:  lock_next   = req_reg.write_data[15:0];
                    OFS_ALTLO: alt_lo_next = req_reg.write_data;
                    OFS_ALTHI: alt_hi_next = req_reg.write_data;
                    OFS_RESETONLY:
                    begin
                        out_data_next = out_data_reg & ~req_reg.write_data[15:0];
                        do_resolve = 1'b1;
                    end
                    OFS_ANALOG: analog_next = req_reg.write_data[15:0];
                    default:    rsp_next.bad_offset = 1'b1;
                endcase
            end
            CMD_DRIVE:
            begin
                if (pin_ok)
                begin
                    // Refuse unless the pin is not in output mode, or is an open drain driven low
                    if ((modes_reg[{pin, 1'b0} +: 2] == MODE_OUTPUT) &&
                        !(types_reg[pin] && !req_reg.pin_level_in))
                    begin
                        rsp_next.drive_refused = 1'b1;
                    end
                    else
                    begin
                        disc_next[pin] = 1'b0;
                        high_next[pin] = req_reg.pin_level_in;
                        do_resolve = 1'b1;
                    end
                end
            end
            CMD_DISCONNECT:
            begin
                disc_next  = disc_reg | req_reg.disconnect_mask;
                do_resolve = 1'b1;
            end
            CMD_PORT_RESET:
            begin
                modes_next    = mode_rst_reg;
                types_next    = '0;
                speeds_next   = speed_rst_reg;
                pulls_next    = pull_rst_reg;
                out_data_next = '0;
                lock_next     = '0;
                alt_lo_next   = '0;
                alt_hi_next   = '0;
                analog_next   = '0;
                disc_next     = '1;
                high_next     = '0;
                prev_levels   = '0;
                in_data_next  = '0;
                do_resolve    = 1'b1;
            end
            default: ;
        endcase

        now_levels = resolve_levels(modes_next, types_next, out_data_next, pulls_next,
                                    disc_next, high_next, prev_levels);
        if (do_resolve)
        begin
            in_data_next       = now_levels;
            rsp_next.rise_mask = ~prev_levels & now_levels;
            rsp_next.fall_mask = prev_levels & ~now_levels;
        end
        rsp_next.input_levels = in_data_next;
    end

    // Commit the port state as the command leaves the request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modes_reg    <= '0;
            types_reg    <= '0;
            speeds_reg   <= '0;
            pulls_reg    <= '0;
            in_data_reg  <= '0;
            out_data_reg <= '0;
            lock_reg     <= '0;
            alt_lo_reg   <= '0;
            alt_hi_reg   <= '0;
            analog_reg   <= '0;
            disc_reg     <= '1;
            high_reg     <= '0;
        end
        else if (advance)
        begin
            modes_reg    <= modes_next;
            types_reg    <= types_next;
            speeds_reg   <= speeds_next;
            pulls_reg    <= pulls_next;
            in_data_reg  <= in_data_next;
            out_data_reg <= out_data_next;
            lock_reg     <= lock_next;
            alt_lo_reg   <= alt_lo_next;
            alt_hi_reg   <= alt_hi_next;
            analog_reg   <= analog_next;
            disc_reg     <= disc_next;
            high_reg     <= high_next;
        end
    end

    // Advance the request and result stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
                req_valid_reg <= 1'b1;
            else if (advance)
                req_valid_reg <= 1'b0;

            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            req_reg <= req;
        if (advance)
            rsp_reg <= rsp_next;
    end

    // A beat that leaves the request register lands in the result register
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid_reg)
        else $error("result register empty after an advance");

    // Edges only name pins that now read at the reported level
    a_rise_matches_level: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> ((rsp_reg.rise_mask & ~rsp_reg.input_levels) == 16'h0 &&
                           (rsp_reg.fall_mask & rsp_reg.input_levels) == 16'h0))
        else $error("edge mask disagrees with input levels");

    // A bad offset never changes pin levels
    a_bad_offset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.bad_offset) |->
            (rsp_reg.rise_mask == 16'h0 && rsp_reg.fall_mask == 16'h0 &&
             rsp_reg.read_data == 32'h0 && !rsp_reg.drive_refused))
        else $error("bad offset beat carries side effects");

    // A refused drive is not a read
    a_refused_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.drive_refused) |-> (rsp_reg.read_data == 32'h0))
        else $error("refused beat carries read data");

    // Stall only with a held request and a held result
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (req_valid_reg && rsp_valid_reg && rsp_stall))
        else $error("request stalled with room in the pipeline");

endmodule

`default_nettype wire

>>> test/gpio_result_checker.sv
// Result checker for the GPIO port pin resolver: predicts each result beat and compares it.
`timescale 1ns / 1ps

module gpio_result_checker
    import gpio_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    input  wire logic        req_stall,
    input  gpio_req_t        req,
    input  wire logic        rsp_valid,
    input  wire logic        rsp_stall,
    input  gpio_rsp_t        rsp,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               fail_count,
    output int               pending
);

    // Shadow of the reset-value registers
    logic [31:0] mode_rst_val;
    logic [31:0] speed_rst_val;
    logic [31:0] pull_rst_val;

    // Shadow of the port state
    logic [31:0] modes;
    logic [31:0] speeds;
    logic [31:0] pulls;
    logic [31:0] alt_lo;
    logic [31:0] alt_hi;
    logic [15:0] otypes;
    logic [15:0] in_levels;
    logic [15:0] out_levels;
    logic [15:0] locks;
    logic [15:0] analog;
    logic [15:0] unlinked;
    logic [15:0] held_high;

    // Edges seen during the beat being predicted
    logic [15:0] rise_acc;
    logic [15:0] fall_acc;

    gpio_rsp_t   expected_rsps[$];
    gpio_rsp_t   want;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, exp_val);
        fail_count++;
    endtask

    // Load the port-reset values into the shadow state
    function automatic void clear_port();
        modes      = mode_rst_val;
        otypes     = '0;
        speeds     = speed_rst_val;
        pulls      = pull_rst_val;
        in_levels  = '0;
        out_levels = '0;
        locks      = '0;
        alt_lo     = '0;
        alt_hi     = '0;
        analog     = '0;
        unlinked   = 16'hFFFF;
        held_high  = '0;
    endfunction

    // Settle every pin level; a floating pin keeps its last level
    function automatic void settle_levels();
        logic [15:0] prev;
        logic [15:0] target;
        logic [15:0] known;
        logic [15:0] now;
        logic [1:0]  pull;
        prev   = in_levels;
        target = out_levels;
        known  = '0;
        for (int i = 0; i < NUM_PINS; i++) begin
            pull = pulls[2*i +: 2];
            if (modes[2*i +: 2] == MODE_OUTPUT) begin
                if (!otypes[i] || !out_levels[i]) begin
                    known[i] = 1'b1;
                end
                else if (!unlinked[i] && !held_high[i]) begin
                    known[i]  = 1'b1;
                    target[i] = 1'b0;
                end
                else if (pull == PULL_UP) begin
                    known[i] = 1'b1;
                end
                else if (pull == PULL_DOWN) begin
                    known[i]  = 1'b1;
                    target[i] = 1'b0;
                end
            end
            else if (!unlinked[i]) begin
                known[i]  = 1'b1;
                target[i] = held_high[i];
            end
            else if (pull == PULL_UP) begin
                known[i]  = 1'b1;
                target[i] = 1'b1;
            end
            else if (pull == PULL_DOWN) begin
                known[i]  = 1'b1;
                target[i] = 1'b0;
            end
        end
        now       = (prev & ~known) | (target & known);
        in_levels = now;
        rise_acc  = rise_acc | (~prev & now);
        fall_acc  = fall_acc | (prev & ~now);
    endfunction

    // Connected outputs that would fight an external driver
    function automatic logic [15:0] fighting_pins();
        logic [15:0] hit;
        hit = '0;
        for (int i = 0; i < NUM_PINS; i++) begin
            if (!unlinked[i] && modes[2*i +: 2] == MODE_OUTPUT && (!otypes[i] || held_high[i]))
                hit[i] = 1'b1;
        end
        return hit;
    endfunction

    // Apply one request to the shadow state and build its result beat
    function automatic gpio_rsp_t predict_result(gpio_req_t r);
        gpio_rsp_t   res;
        logic [15:0] hit;
        res      = '0;
        rise_acc = '0;
        fall_acc = '0;
        case (r.cmd)
            CMD_READ: begin
                case (r.addr)
                    OFS_MODE:      res.read_data = modes;
                    OFS_TYPE:      res.read_data = {16'h0, otypes};
                    OFS_SPEED:     res.read_data = speeds;
                    OFS_PULL:      res.read_data = pulls;
                    OFS_IN:        res.read_data = {16'h0, in_levels};
                    OFS_OUT:       res.read_data = {16'h0, out_levels};
                    OFS_SETRESET:  res.read_data = '0;
                    OFS_LOCK:      res.read_data = {16'h0, locks};
                    OFS_ALTLO:     res.read_data = alt_lo;
                    OFS_ALTHI:     res.read_data = alt_hi;
                    OFS_RESETONLY: res.read_data = '0;
                    OFS_ANALOG:    res.read_data = {16'h0, analog};
                    default:       res.bad_offset = 1'b1;
                endcase
            end
            CMD_WRITE: begin
                case (r.addr)
                    OFS_MODE, OFS_TYPE: begin
                        if (r.addr == OFS_MODE)
                            modes = r.write_data;
                        else
                            otypes = r.write_data[15:0];
                        hit      = fighting_pins();
                        unlinked = unlinked | hit;
                        if (hit != '0)
                            res.drive_refused = 1'b1;
                        settle_levels();
                    end
                    OFS_SPEED: speeds = r.write_data;
                    OFS_PULL: begin
                        pulls = r.write_data;
                        settle_levels();
                    end
                    OFS_IN: ;
                    OFS_OUT: begin
                        out_levels = r.write_data[15:0];
                        settle_levels();
                    end
                    OFS_SETRESET: begin
                        // set bits win over reset bits
                        out_levels = (out_levels & ~r.write_data[31:16]) | r.write_data[15:0];
                        settle_levels();
                    end
                    OFS_LOCK:  locks = r.write_data[15:0];
                    OFS_ALTLO: alt_lo = r.write_data;
                    OFS_ALTHI: alt_hi = r.write_data;
                    OFS_RESETONLY: begin
                        out_levels = out_levels & ~r.write_data[15:0];
                        settle_levels();
                    end
                    OFS_ANALOG: analog = r.write_data[15:0];
                    default:    res.bad_offset = 1'b1;
                endcase
            end
            CMD_DRIVE: begin
                // outputs accept only an open-drain low
                if (modes[2*r.pin_index +: 2] == MODE_OUTPUT &&
                    !(otypes[r.pin_index] && !r.pin_level_in)) begin
                    res.drive_refused = 1'b1;
                end
                else begin
                    unlinked[r.pin_index]  = 1'b0;
                    held_high[r.pin_index] = r.pin_level_in;
                    settle_levels();
                end
            end
            CMD_DISCONNECT: begin
                unlinked = unlinked | r.disconnect_mask;
                settle_levels();
            end
            CMD_PORT_RESET: begin
                clear_port();
                settle_levels();
            end
            default: ;
        endcase
        res.input_levels = in_levels;
        res.rise_mask    = rise_acc;
        res.fall_mask    = fall_acc;
        return res;
    endfunction

    // Track config writes, predict accepted requests, compare accepted results
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_rst_val  = '0;
            speed_rst_val = '0;
            pull_rst_val  = '0;
            clear_port();
            expected_rsps.delete();
            fail_count = 0;
            pending    = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MODE_RESET:  mode_rst_val = cfg_data;
                    CFG_SPEED_RESET: speed_rst_val = cfg_data;
                    CFG_PULL_RESET:  pull_rst_val = cfg_data;
                    default: ;
                endcase
            end
            if (req_valid && !req_stall)
                expected_rsps.push_back(predict_result(req));
            if (rsp_valid && !rsp_stall) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("result beat with nothing expected", rsp.read_data, '0);
                end
                else begin
                    want = expected_rsps.pop_front();
                    if (rsp.read_data !== want.read_data)
                        report_mismatch("read_data", rsp.read_data, want.read_data);
                    if (rsp.input_levels !== want.input_levels)
                        report_mismatch("input_levels", {16'h0, rsp.input_levels},
                                        {16'h0, want.input_levels});
                    if (rsp.rise_mask !== want.rise_mask)
                        report_mismatch("rise_mask", {16'h0, rsp.rise_mask},
                                        {16'h0, want.rise_mask});
                    if (rsp.fall_mask !== want.fall_mask)
                        report_mismatch("fall_mask", {16'h0, rsp.fall_mask},
                                        {16'h0, want.fall_mask});
                    if (rsp.drive_refused !== want.drive_refused)
                        report_mismatch("drive_refused", {31'h0, rsp.drive_refused},
                                        {31'h0, want.drive_refused});
                    if (rsp.bad_offset !== want.bad_offset)
                        report_mismatch("bad_offset", {31'h0, rsp.bad_offset},
                                        {31'h0, want.bad_offset});
                end
            end
            pending = expected_rsps.size();
        end
    end

endmodule

>>> test/tb_top.sv
// Testbench top for the GPIO port pin resolver: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import gpio_pkg::*;

    localparam int         CLK_PERIOD       = 12;
    localparam int         RANDOM_PER_HALF  = 80;
    localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    gpio_req_t   req;
    logic        rsp_valid;
    logic        rsp_stall;
    gpio_rsp_t   rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    int          fail_count;
    int          pending;
    int          idle_pct;
    int          stall_pct;

    gpio_port_pin_resolver_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gpio_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #(CLK_PERIOD / 2);
        clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic gpio_req_t make_beat(logic [2:0] cmd, logic [9:0] addr,
                                            logic [31:0] data, logic [3:0] pin,
                                            logic level, logic [15:0] mask);
        gpio_req_t r;
        r.cmd             = cmd;
        r.addr            = addr;
        r.write_data      = data;
        r.pin_index       = pin;
        r.pin_level_in    = level;
        r.disconnect_mask = mask;
        return r;
    endfunction

    // Mostly known register offsets, now and then any offset at all
    function automatic logic [9:0] pick_offset();
        logic [9:0] ofs;
        if ($urandom_range(0, 9) == 0)
            return 10'($urandom);
        case ($urandom_range(0, 11))
            0:       ofs = OFS_MODE;
            1:       ofs = OFS_TYPE;
            2:       ofs = OFS_SPEED;
            3:       ofs = OFS_PULL;
            4:       ofs = OFS_IN;
            5:       ofs = OFS_OUT;
            6:       ofs = OFS_SETRESET;
            7:       ofs = OFS_LOCK;
            8:       ofs = OFS_ALTLO;
            9:       ofs = OFS_ALTHI;
            10:      ofs = OFS_RESETONLY;
            default: ofs = OFS_ANALOG;
        endcase
        return ofs;
    endfunction

    // Weight toward writes and drives so pins get configured and driven
    function automatic gpio_req_t random_beat();
        gpio_req_t r;
        int        pick;
        r.addr            = pick_offset();
        r.write_data      = $urandom;
        r.pin_index       = 4'($urandom_range(0, 15));
        r.pin_level_in    = 1'($urandom_range(0, 1));
        r.disconnect_mask = 16'($urandom & $urandom & $urandom);
        pick              = $urandom_range(0, 99);
        if (pick < 22)
            r.cmd = CMD_READ;
        else if (pick < 55)
            r.cmd = CMD_WRITE;
        else if (pick < 85)
            r.cmd = CMD_DRIVE;
        else if (pick < 92)
            r.cmd = CMD_DISCONNECT;
        else if (pick < 96)
            r.cmd = CMD_PORT_RESET;
        else
            r.cmd = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
        return r;
    endfunction

    // Present one request beat, with random idle cycles ahead of it
    task automatic send_beat(input gpio_req_t r);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // Hold off until every expected result beat has come back
    task automatic drain_port();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic cfg_beat(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic load_reset_values(input logic [31:0] mode_val, input logic [31:0] speed_val,
                                     input logic [31:0] pull_val);
        cfg_beat(CFG_MODE_RESET, mode_val);
        cfg_beat(CFG_SPEED_RESET, speed_val);
        cfg_beat(CFG_PULL_RESET, pull_val);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            send_beat(random_beat());
    endtask

    // Main stimulus
    initial
    begin
        idle_pct  = 0;
        stall_pct = 0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        rsp_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_MODE_RESET;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_reset_values(32'h5555_5555, 32'hFFFF_FFFF, 32'hAAAA_AAAA);

        // Directed: register extremes, every command, each corner of pin resolution
        send_beat(make_beat(CMD_READ, OFS_MODE, '0, '0, 1'b0, '0));
        send_beat(make_beat(CMD_WRITE, OFS_MODE, 32'h5555_5555, '0, 1'b0, '0));
        // push-pull output refuses an external drive
        send_beat(make_beat(CMD_DRIVE, '0, '0, 4'd0, 1'b1, '0));
        send_beat(make_beat(CMD_WRITE, OFS_TYPE, 32'hFFFF_FFFF, '0, 1'b0, '0));
        // open drain released with nothing attached floats
        send_beat(make_beat(CMD_WRITE, OFS_OUT, 32'hFFFF_FFFF, '0, 1'b0, '0));
        send_beat(make_beat(CMD_WRITE, OFS_PULL, 32'hAAAA_AAAA, '0, 1'b0, '0));
        send_beat(make_beat(CMD_WRITE, OFS_PULL, 32'h5555_5555, '0, 1'b0, '0));
        // open-drain low drive is accepted and pulls the pin down
        send_beat(make_beat(CMD_DRIVE, '0, '0, 4'd15, 1'b0, '0));
        send_beat(make_beat(CMD_DRIVE, '0, '0, 4'd3, 1'b1, '0));
        // switching to push-pull forces the driven pin off
        send_beat(make_beat(CMD_WRITE, OFS_TYPE, '0, '0, 1'b0, '0));
        send_beat(make_beat(CMD_WRITE, OFS_SETRESET, 32'hFFFF_FFFF, '0, 1'b0, '0));
        send_beat(make_beat(CMD_WRITE, OFS_RESETONLY, 32'hFFFF_00FF, '0, 1'b0, '0));
        send_beat(make_beat(CMD_READ, OFS_SETRESET, '0, '0, 1'b0, '0));
        send_beat(make_beat(CMD_READ, OFS_RESETONLY, '0, '0, 1'b0, '0));
        send_beat(make_beat(CMD_WRITE, OFS_IN, 32'hFFFF_FFFF, '0, 1'b0, '0));
        send_beat(make_beat(CMD_WRITE, OFS_LOCK, 32'hFFFF_FFFF, '0, 1'b0, '0));
        send_beat(make_beat(CMD_READ, OFS_LOCK, '0, '0, 1'b0, '0));
        send_beat(make_beat(CMD_WRITE, OFS_MODE, '0, '0, 1'b0, '0));
        send_beat(make_beat(CMD_DRIVE, '0, '0, 4'd7, 1'b1, '0));
        // pull code three behaves as no pull
        send_beat(make_beat(CMD_WRITE, OFS_PULL, 32'hFFFF_FFFF, '0, 1'b0, '0));
        send_beat(make_beat(CMD_DISCONNECT, '0, '0, '0, 1'b0, 16'hFFFF));
        send_beat(make_beat(CMD_READ, 10'h3FF, '0, '0, 1'b0, '0));
        send_beat(make_beat(CMD_WRITE, 10'h002, 32'hFFFF_FFFF, '0, 1'b0, '0));
        send_beat(make_beat(CMD_PORT_RESET, '0, '0, '0, 1'b0, '0));
        send_beat(make_beat(CMD_LAST_UNUSED, '0, '0, '0, 1'b0, '0));

        // Random phases under different idle and stall patterns and reset values
        for (int phase = 0; phase < 4; phase++)
        begin
            drain_port();
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    load_reset_values('0, '0, '0);
                end
                1:
                begin
                    idle_pct  = 60;
                    stall_pct = 0;
                    load_reset_values(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 60;
                    load_reset_values($urandom, $urandom, $urandom);
                end
                default:
                begin
                    idle_pct  = 22;
                    stall_pct = 22;
                    load_reset_values($urandom, $urandom, $urandom);
                end
            endcase
            send_beat(make_beat(CMD_PORT_RESET, '0, '0, '0, 1'b0, '0));
            send_random(RANDOM_PER_HALF);
            drain_port();
            send_random(RANDOM_PER_HALF);
        end

        drain_port();
        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Give up after a generous bound
    initial
    begin
        #(CLK_PERIOD * 400000);
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
src/gpio_pkg.sv
src/gpio_port_pin_resolver_unit.sv
test/gpio_result_checker.sv
test/tb_top.sv
